// ===== hw/rtl/h264fua_pkg.sv =====
// Package: shared types and constants of the H.264 FU-A packetiser.
`timescale 1ns / 1ps
package h264fua_pkg;

    // Field widths of the byte channels
    localparam int BYTE_W         = 8;
    localparam int NAL_LEN_W      = 21;
    localparam int PAYLOAD_W      = 16;
    localparam int SEQ_W          = 16;
    localparam int TS_W           = 32;

    // Longest NAL unit accepted; longer lengths saturate to it
    localparam int NAL_LENGTH_MAX = 1048576;

    // Configuration port
    localparam int CFG_INDEX_W    = 8;
    localparam int CFG_DATA_W     = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD     = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_TIMESTAMP_STEP  = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_SEQUENCE  = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_TIMESTAMP = CFG_INDEX_W'(3);

    // Register reset values
    localparam logic [PAYLOAD_W-1:0] MAX_PAYLOAD_RESET     = PAYLOAD_W'(1400);
    localparam logic [TS_W-1:0]      TIMESTAMP_STEP_RESET  = TS_W'(90000 / 30);
    localparam logic [SEQ_W-1:0]     FIRST_SEQUENCE_RESET  = '0;
    localparam logic [TS_W-1:0]      FIRST_TIMESTAMP_RESET = '0;

    // Limits applied to the payload size register
    localparam logic [PAYLOAD_W-1:0] PAYLOAD_FLOOR = PAYLOAD_W'(16);
    localparam logic [PAYLOAD_W-1:0] PAYLOAD_CEIL  = PAYLOAD_W'(65000);

    // NAL header fields and FU-A codes
    localparam logic [4:0] FU_A_TYPE = 5'd28;
    localparam logic [4:0] NAL_SEI   = 5'd6;
    localparam logic [4:0] NAL_SPS   = 5'd7;
    localparam logic [4:0] NAL_PPS   = 5'd8;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One queue entry: a data byte, optionally preceded by the two FU-A bytes
    typedef struct packed {
        logic              hdr_en;
        logic [BYTE_W-1:0] fu_ind;
        logic [BYTE_W-1:0] fu_hdr;
        logic [BYTE_W-1:0] data;
        logic              data_first;
        logic              data_last;
        logic [SEQ_W-1:0]  seq;
        logic [TS_W-1:0]   ts;
    } fua_entry_t;

    // One output word
    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              packet_first;
        logic              packet_last;
        logic [SEQ_W-1:0]  sequence_number;
        logic [TS_W-1:0]   rtp_timestamp;
    } pay_word_t;

    // Back-end position within an entry that carries FU-A bytes
    typedef enum logic [1:0] {
        PH_FU   = 2'b01,
        PH_DATA = 2'b10
    } back_phase_t;

endpackage

// ===== hw/rtl/h264fua_if.sv =====
// Interfaces: NAL byte input channel and RTP payload output channel.
`timescale 1ns / 1ps
interface h264fua_nal_if import h264fua_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [BYTE_W-1:0]    nal_byte;
    logic                 nal_first;
    logic [NAL_LEN_W-1:0] nal_length;

    modport source (output valid, nal_byte, nal_first, nal_length, input ready);
    modport sink   (input valid, nal_byte, nal_first, nal_length, output ready);
endinterface

interface h264fua_pay_if import h264fua_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic              packet_first;
    logic              packet_last;
    logic [SEQ_W-1:0]  sequence_number;
    logic [TS_W-1:0]   rtp_timestamp;

    modport source (output valid, payload_byte, packet_first, packet_last,
                    sequence_number, rtp_timestamp, input ready);
    modport sink   (input valid, payload_byte, packet_first, packet_last,
                    sequence_number, rtp_timestamp, output ready);
endinterface

// ===== hw/rtl/h264_rtp_fua_packetizer.sv =====
// Top level of the H.264 RTP packetiser with FU-A fragmentation.
`timescale 1ns / 1ps
// Usage
//   nal: one NAL unit byte per word, header byte first with nal_first high and
//   the total unit length in nal_length. pay: one RTP payload byte per word,
//   with packet_first / packet_last framing, sequence number and timestamp.
//   Both channels move a word when valid and ready are high at a clock edge.
//   cfg_we / cfg_index / cfg_data write the payload limit (0), timestamp step
//   (1), first sequence number (2) and first timestamp (3); writing 2 or 3 also
//   loads the running counter. Write only while no word is in flight.
// Data flow
//   A byte accepted on nal is written into the queue and then loaded into
//   the output register, from which pay takes it. Every NAL byte gives one
//   payload word, but for the header byte of a fragmented unit, which gives
//   none; the first body byte of a fragment gives two more (FU indicator, FU
//   header). The output side sustains one word per cycle while pay is ready;
//   the input takes one word per cycle for single-packet units while the
//   queue has room; fragments fill the four-entry queue and wait on nal.ready.
// Reset and stalls
//   Reset restores the register defaults, clears the queue and output register
//   and loads the counters from the start values. When pay is stalled the
//   output word holds and the queue fills; nal.ready falls when it is full.
module h264_rtp_fua_packetizer import h264fua_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    h264fua_nal_if.sink            nal,
    h264fua_pay_if.source          pay,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic       push;
    fua_entry_t push_entry;
    logic       full;
    logic       pop;
    fua_entry_t head;
    logic       empty;

    // Front end: decisions per NAL byte
    h264fua_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .nal        (nal),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decoupling queue
    h264fua_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    // Back end: payload word generation
    h264fua_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .pay   (pay)
    );

endmodule

// ===== hw/rtl/h264fua_front.sv =====
// Front end: configuration registers, NAL tracking and fragment decisions.
`timescale 1ns / 1ps
module h264fua_front import h264fua_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    h264fua_nal_if.sink            nal,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   queue_full,
    output logic                   push,
    output fua_entry_t             push_entry
);

    localparam logic [NAL_LEN_W-1:0] LEN_MAX = NAL_LEN_W'(NAL_LENGTH_MAX);

    logic [PAYLOAD_W-1:0] max_payload_reg;
    logic [TS_W-1:0]      ts_step_reg;
    logic [SEQ_W-1:0]     first_seq_reg;
    logic [TS_W-1:0]      first_ts_reg;

    logic [BYTE_W-1:0]    header_reg,     header_next;
    logic [NAL_LEN_W-1:0] bytes_left_reg, bytes_left_next;
    logic [PAYLOAD_W-1:0] fill_reg,       fill_next;
    logic                 split_reg,      split_next;
    logic                 first_frag_reg, first_frag_next;
    logic [SEQ_W-1:0]     seq_reg,        seq_next;
    logic [TS_W-1:0]      ts_reg,         ts_next;

    logic                 accept;
    logic [PAYLOAD_W-1:0] limit;
    logic [NAL_LEN_W-1:0] len_sat;
    logic                 fits;
    logic [NAL_LEN_W:0]   left_plus_fill;
    logic [PAYLOAD_W-1:0] frag_lim;
    logic [PAYLOAD_W-1:0] fill_inc;
    logic                 frag_end;
    logic                 ts_skip;

    assign nal.ready = !queue_full;
    assign accept    = nal.valid && !queue_full;

    // Payload limit saturated to its legal range
    always_comb
    begin
        if (max_payload_reg < PAYLOAD_FLOOR)
            limit = PAYLOAD_FLOOR;
        else if (max_payload_reg > PAYLOAD_CEIL)
            limit = PAYLOAD_CEIL;
        else
            limit = max_payload_reg;
    end

    // Length carried on the header byte, saturated to the legal range
    always_comb
    begin
        if (nal.nal_length == '0)
            len_sat = NAL_LEN_W'(1);
        else if (nal.nal_length > LEN_MAX)
            len_sat = LEN_MAX;
        else
            len_sat = nal.nal_length;
    end

    assign fits = len_sat <= NAL_LEN_W'(limit);

    // The first fragment gives up one byte when the body equals the limit exactly
    assign left_plus_fill = {1'b0, bytes_left_reg} + (NAL_LEN_W + 1)'(fill_reg);
    assign frag_lim = (first_frag_reg && left_plus_fill == (NAL_LEN_W + 1)'(limit))
                      ? limit - PAYLOAD_W'(1) : limit;
    assign fill_inc = fill_reg + PAYLOAD_W'(1);
    assign frag_end = (fill_inc >= frag_lim) || (bytes_left_reg == NAL_LEN_W'(1));

    // Parameter sets and SEI sent as a single packet do not move the timestamp
    assign ts_skip = header_reg[4:0] inside {NAL_SEI, NAL_SPS, NAL_PPS};

    // Per-byte decisions of the packetiser
    always_comb
    begin
        header_next     = header_reg;
        bytes_left_next = bytes_left_reg;
        fill_next       = fill_reg;
        split_next      = split_reg;
        first_frag_next = first_frag_reg;
        seq_next        = seq_reg;
        ts_next         = ts_reg;
        push            = 1'b0;

        push_entry.hdr_en     = 1'b0;
        push_entry.fu_ind     = {1'b0, header_reg[6:5], FU_A_TYPE};
        push_entry.fu_hdr     = {first_frag_reg,
                                 !first_frag_reg && (bytes_left_reg <= NAL_LEN_W'(limit)),
                                 1'b0, header_reg[4:0]};
        push_entry.data       = nal.nal_byte;
        push_entry.data_first = 1'b0;
        push_entry.data_last  = 1'b0;
        push_entry.seq        = seq_reg;
        push_entry.ts         = ts_reg;

        if (accept)
        begin
            if (nal.nal_first)
            begin
                header_next     = nal.nal_byte;
                bytes_left_next = len_sat - NAL_LEN_W'(1);
                fill_next       = '0;
                first_frag_next = 1'b0;
                if (fits)
                begin
                    split_next            = 1'b0;
                    push                  = 1'b1;
                    push_entry.data_first = 1'b1;
                    push_entry.data_last  = (len_sat == NAL_LEN_W'(1));
                    if (len_sat == NAL_LEN_W'(1))
                    begin
                        seq_next = seq_reg + SEQ_W'(1);
                        if (!(nal.nal_byte[4:0] inside {NAL_SEI, NAL_SPS, NAL_PPS}))
                            ts_next = ts_reg + ts_step_reg;
                    end
                end
                else
                begin
                    split_next      = 1'b1;
                    first_frag_next = 1'b1;
                end
            end
            else if (bytes_left_reg != '0)
            begin
                push            = 1'b1;
                bytes_left_next = bytes_left_reg - NAL_LEN_W'(1);
                if (!split_reg)
                begin
                    // Byte of a single-packet unit
                    push_entry.data_last = (bytes_left_reg == NAL_LEN_W'(1));
                    if (bytes_left_reg == NAL_LEN_W'(1))
                    begin
                        seq_next = seq_reg + SEQ_W'(1);
                        if (!ts_skip)
                            ts_next = ts_reg + ts_step_reg;
                    end
                end
                else
                begin
                    // Body byte of a fragment, FU-A bytes ahead of its first one
                    push_entry.hdr_en    = (fill_reg == '0);
                    push_entry.data_last = frag_end;
                    fill_next            = fill_inc;
                    if (frag_end)
                    begin
                        seq_next        = seq_reg + SEQ_W'(1);
                        fill_next       = '0;
                        first_frag_next = 1'b0;
                        if (bytes_left_reg == NAL_LEN_W'(1))
                        begin
                            ts_next    = ts_reg + ts_step_reg;
                            split_next = 1'b0;
                        end
                    end
                end
            end
        end

        // Loading a start value also loads its counter
        if (cfg_we)
        begin
            case (cfg_index)
                REG_FIRST_SEQUENCE:  seq_next = cfg_data[SEQ_W-1:0];
                REG_FIRST_TIMESTAMP: ts_next  = cfg_data[TS_W-1:0];
                default:             ;
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
            ts_step_reg     <= TIMESTAMP_STEP_RESET;
            first_seq_reg   <= FIRST_SEQUENCE_RESET;
            first_ts_reg    <= FIRST_TIMESTAMP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_PAYLOAD:     max_payload_reg <= cfg_data[PAYLOAD_W-1:0];
                REG_TIMESTAMP_STEP:  ts_step_reg     <= cfg_data[TS_W-1:0];
                REG_FIRST_SEQUENCE:  first_seq_reg   <= cfg_data[SEQ_W-1:0];
                REG_FIRST_TIMESTAMP: first_ts_reg    <= cfg_data[TS_W-1:0];
                default:             ;
            endcase
        end
    end

    // NAL tracking state and packet counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg     <= '0;
            bytes_left_reg <= '0;
            fill_reg       <= '0;
            split_reg      <= 1'b0;
            first_frag_reg <= 1'b0;
            seq_reg        <= FIRST_SEQUENCE_RESET;
            ts_reg         <= FIRST_TIMESTAMP_RESET;
        end
        else
        begin
            header_reg     <= header_next;
            bytes_left_reg <= bytes_left_next;
            fill_reg       <= fill_next;
            split_reg      <= split_next;
            first_frag_reg <= first_frag_next;
            seq_reg        <= seq_next;
            ts_reg         <= ts_next;
        end
    end

    // A unit being fragmented always has body bytes still to come
    a_split_has_body: assert property (@(posedge clk) disable iff (!rst_n)
        split_reg |-> bytes_left_reg != '0)
        else $error("fragmenting with no bytes left");

    // The remaining count never exceeds the longest unit less its header
    a_left_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_left_reg < LEN_MAX)
        else $error("remaining byte count out of range");

    // The start value registers hold what the counters were loaded with
    a_seq_load: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == REG_FIRST_SEQUENCE |=> seq_reg == first_seq_reg)
        else $error("sequence counter not loaded from its start value");

    a_ts_load: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == REG_FIRST_TIMESTAMP |=> ts_reg == first_ts_reg)
        else $error("timestamp counter not loaded from its start value");

endmodule

// ===== hw/rtl/h264fua_queue.sv =====
// Short queue of packetiser entries between front and back end.
`timescale 1ns / 1ps
module h264fua_queue import h264fua_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  fua_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output fua_entry_t head,
    output logic       empty
);

    fua_entry_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;

    assign full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        if (pop)
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond its depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

endmodule

// ===== hw/rtl/h264fua_back.sv =====
// Back end: expands queue entries into payload words behind an output register.
`timescale 1ns / 1ps
module h264fua_back import h264fua_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  fua_entry_t    head,
    input  logic          empty,
    output logic          pop,
    h264fua_pay_if.source pay
);

    fua_entry_t  cur_reg,   cur_next;
    logic        cur_valid_reg, cur_valid_next;
    back_phase_t phase_reg, phase_next;
    logic        out_valid_reg, out_valid_next;
    pay_word_t   out_reg,   out_next;
    logic        load;

    // The output register can take a word when empty or being drained
    assign load = !out_valid_reg || pay.ready;

    // Word selection: the held entry first, otherwise straight from the queue
    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !pay.ready;
        out_next       = out_reg;
        pop            = 1'b0;

        if (load)
        begin
            if (cur_valid_reg)
            begin
                out_valid_next           = 1'b1;
                out_next.sequence_number = cur_reg.seq;
                out_next.rtp_timestamp   = cur_reg.ts;
                case (phase_reg)
                    PH_FU:
                    begin
                        out_next.payload_byte = cur_reg.fu_hdr;
                        out_next.packet_first = 1'b0;
                        out_next.packet_last  = 1'b0;
                        phase_next            = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        out_next.payload_byte = cur_reg.data;
                        out_next.packet_first = cur_reg.data_first;
                        out_next.packet_last  = cur_reg.data_last;
                        cur_valid_next        = 1'b0;
                    end
                    default:
                    begin
                        out_valid_next = 1'b0;
                        cur_valid_next = 1'b0;
                    end
                endcase
            end
            else if (!empty)
            begin
                pop                      = 1'b1;
                out_valid_next           = 1'b1;
                out_next.sequence_number = head.seq;
                out_next.rtp_timestamp   = head.ts;
                if (head.hdr_en)
                begin
                    out_next.payload_byte = head.fu_ind;
                    out_next.packet_first = 1'b1;
                    out_next.packet_last  = 1'b0;
                    cur_next              = head;
                    cur_valid_next        = 1'b1;
                    phase_next            = PH_FU;
                end
                else
                begin
                    out_next.payload_byte = head.data;
                    out_next.packet_first = head.data_first;
                    out_next.packet_last  = head.data_last;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            phase_reg     <= PH_FU;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    assign pay.valid           = out_valid_reg;
    assign pay.payload_byte    = out_reg.payload_byte;
    assign pay.packet_first    = out_reg.packet_first;
    assign pay.packet_last     = out_reg.packet_last;
    assign pay.sequence_number = out_reg.sequence_number;
    assign pay.rtp_timestamp   = out_reg.rtp_timestamp;

    // The queue is never read while a held entry still has words to give
    a_no_pop_while_held: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> !pop)
        else $error("queue read while an entry is still being expanded");

endmodule
